FILE: hw/rtl/bitmap_slice_allocator_macros.svh
// Assertion shorthands for the slice allocator; they sample on i_clk and
// stay quiet while i_rst_n is low.
`ifndef BITMAP_SLICE_ALLOCATOR_MACROS_SVH
`define BITMAP_SLICE_ALLOCATOR_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define BSA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BSA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/bsa_pkg.sv
package bsa_pkg;

    // Pool geometry
    localparam int SLICE_LOG2  = 6;
    localparam int POOL_LOG2   = 17;
    localparam int POOL_BYTES  = 1 << POOL_LOG2;
    localparam int SLICE_BYTES = 1 << SLICE_LOG2;
    localparam int IDX_W       = POOL_LOG2 - SLICE_LOG2;
    localparam int NUM_SLICES  = 1 << IDX_W;

    // Bitmap words
    localparam int WORD_W    = 16;
    localparam int BIT_W     = 4;
    localparam int NUM_WORDS = NUM_SLICES / WORD_W;
    localparam int WORD_AW   = IDX_W - BIT_W;

    // The bitmap lives in the top slices of the pool
    localparam int MAP_ALIGN  = (SLICE_LOG2 == 6) ? 256 : 128;
    localparam int MAP_BYTES  = ((NUM_SLICES / 8) + MAP_ALIGN - 1) & ~(MAP_ALIGN - 1);
    localparam int TAIL_FIRST = (POOL_BYTES - MAP_BYTES) >> SLICE_LOG2;

    // Item field widths
    localparam int ADDR_W = 17;
    localparam int CNT_W  = 17;
    localparam logic [CNT_W-1:0] FREE_RESET = CNT_W'(POOL_BYTES - MAP_BYTES);

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_ALLOCATED = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_FREED     = 2'd2,
        STAT_NOT_ALLOC = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_CHK,
        ST_DONE
    } t_state;

    // Bitmap word after reset: tail slices set, all others clear
    function automatic logic [WORD_W-1:0] reset_word(input logic [WORD_AW-1:0] w);
        logic [WORD_W-1:0] v;
        v = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (int'(w) * WORD_W + b >= TAIL_FIRST) begin
                v[b] = 1'b1;
            end
        end
        return v;
    endfunction

    // Position of the lowest set bit
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                pos = BIT_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

FILE: hw/rtl/bsa_if.sv
// Request channel: one alloc or free per item
interface bsa_req_if import bsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output req_type, output free_address, input ready);
    modport sink   (input valid, input req_type, input free_address, output ready);
endinterface

// Response channel: one result item per request
interface bsa_rsp_if import bsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] slice_address;
    logic [CNT_W-1:0]  free_bytes;

    modport source (output valid, output status, output slice_address, output free_bytes,
                    input ready);
    modport sink   (input valid, input status, input slice_address, input free_bytes,
                    output ready);
endinterface

FILE: hw/rtl/bitmap_slice_allocator.sv
// Slice allocator over one 128 KiB pool of 64-byte slices, one bitmap bit per
// slice in a 128 x 16-bit RAM. A free reads the word, checks the bit, then
// writes back and responds. An alloc reads one bitmap word per cycle starting
// at the word that holds the lowest-free hint, up to the first word with a
// clear bit or the last word; the single RAM read port sets that rate. An
// alloc with no free bytes left, or with the hint past the last slice,
// answers pool full without a scan. One request is in flight at a time; a new
// one is taken as soon as the previous result sits in the output register,
// and a result waits there until the sink takes it. The top slices that hold
// the bitmap start set and are never freed. There is no clearing pass after
// reset: per-word valid bits stand in for it.
`include "bitmap_slice_allocator_macros.svh"

module bitmap_slice_allocator import bsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsa_req_if.sink   i_req,
    bsa_rsp_if.source o_rsp
);

    localparam logic [WORD_W-1:0]  ONES      = {WORD_W{1'b1}};
    localparam logic [WORD_AW-1:0] LAST_WORD = {WORD_AW{1'b1}};

    // Control state
    t_state                r_state, n_state;
    logic [IDX_W:0]        r_hint, n_hint;
    logic [CNT_W-1:0]      r_free_cnt, n_free_cnt;
    logic [NUM_WORDS-1:0]  r_vld;
    logic                  r_q_vld;
    logic                  r_out_valid;

    // Per-item working registers
    logic [WORD_AW-1:0]    r_q_word;
    logic [WORD_AW-1:0]    r_chk_word;
    logic                  r_first;
    logic [IDX_W-1:0]      r_idx;
    t_status               r_status;
    logic                  r_wr_pend;
    logic [WORD_W-1:0]     r_wr_data;

    // Output register
    t_status               r_out_status;
    logic [ADDR_W-1:0]     r_out_addr;
    logic [CNT_W-1:0]      r_out_bytes;

    // Handshake and datapath wires
    logic                  w_accept;
    logic                  w_slot_free;
    logic                  w_finish;
    logic [IDX_W-1:0]      w_in_idx;
    logic [WORD_W-1:0]     w_ram_q;
    logic [WORD_W-1:0]     w_cur_word;
    logic [WORD_W-1:0]     w_scan_mask;
    logic [WORD_W-1:0]     w_scan_clear;
    logic                  w_scan_found;
    logic [BIT_W-1:0]      w_scan_pos;
    logic                  w_scan_last;
    logic                  w_free_ok;
    logic                  w_ram_re;
    logic [WORD_AW-1:0]    w_ram_raddr;
    logic                  w_ram_we;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign w_finish    = (r_state == ST_DONE) && w_slot_free;
    assign w_in_idx    = IDX_W'(i_req.free_address >> SLICE_LOG2);

    // Words never written read as their reset value
    assign w_cur_word = r_q_vld ? w_ram_q : reset_word(r_q_word);

    // Scan one word: skip bits below the hint in the first word
    assign w_scan_mask  = r_first ? (ONES << r_hint[BIT_W-1:0]) : ONES;
    assign w_scan_clear = ~w_cur_word & w_scan_mask;
    assign w_scan_found = |w_scan_clear;
    assign w_scan_pos   = lowest_set(w_scan_clear);
    assign w_scan_last  = (r_chk_word == LAST_WORD);

    // Free check: tail slices are protected
    assign w_free_ok = (int'(r_idx) < TAIL_FIRST) && w_cur_word[r_idx[BIT_W-1:0]];

    bsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx[IDX_W-1:BIT_W]),
        .i_wdata (r_wr_data),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_q)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == REQ_FREE) begin
                        n_state = ST_FREE_CHK;
                    end else if (r_free_cnt == '0 || r_hint[IDX_W]) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (w_scan_found || w_scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_FREE_CHK: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // RAM control, count and hint updates
    always_comb begin
        w_ram_re    = 1'b0;
        w_ram_raddr = r_chk_word + 1'b1;
        w_ram_we    = 1'b0;
        n_free_cnt  = r_free_cnt;
        n_hint      = r_hint;
        unique case (r_state)
            ST_IDLE: begin
                w_ram_re = w_accept;
                if (i_req.req_type == REQ_FREE) begin
                    w_ram_raddr = w_in_idx[IDX_W-1:BIT_W];
                end else begin
                    w_ram_raddr = r_hint[IDX_W-1:BIT_W];
                end
            end
            ST_SCAN: begin
                // speculative read of the following word
                w_ram_re = 1'b1;
            end
            ST_FREE_CHK: begin
                w_ram_re = 1'b0;
            end
            ST_DONE: begin
                w_ram_we = w_finish && r_wr_pend;
                case (r_status) inside
                    STAT_ALLOCATED: begin
                        n_free_cnt = r_free_cnt - CNT_W'(SLICE_BYTES);
                        n_hint     = {1'b0, r_idx} + 1'b1;
                    end
                    STAT_FREED, STAT_NOT_ALLOC: begin
                        if (r_status == STAT_FREED) begin
                            n_free_cnt = r_free_cnt + CNT_W'(SLICE_BYTES);
                        end
                        if (r_hint > {1'b0, r_idx}) begin
                            n_hint = {1'b0, r_idx};
                        end
                    end
                    default: begin
                        n_free_cnt = r_free_cnt;
                    end
                endcase
            end
            default: begin
                w_ram_re = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hint      <= '0;
            r_free_cnt  <= FREE_RESET;
            r_vld       <= '0;
            r_q_vld     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ram_re) begin
                r_q_vld <= r_vld[w_ram_raddr];
            end
            if (w_finish) begin
                r_hint     <= n_hint;
                r_free_cnt <= n_free_cnt;
                if (r_wr_pend) begin
                    r_vld[r_idx[IDX_W-1:BIT_W]] <= 1'b1;
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (w_ram_re) begin
            r_q_word <= w_ram_raddr;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_idx      <= w_in_idx;
                    r_chk_word <= r_hint[IDX_W-1:BIT_W];
                    r_first    <= 1'b1;
                    r_status   <= STAT_FULL;
                    r_wr_pend  <= 1'b0;
                end
            end
            ST_SCAN: begin
                // advance one word, and hold any hit for write-back
                r_chk_word <= r_chk_word + 1'b1;
                r_first    <= 1'b0;
                if (w_scan_found) begin
                    r_idx     <= {r_chk_word, w_scan_pos};
                    r_wr_data <= w_cur_word | (WORD_W'(1) << w_scan_pos);
                    r_status  <= STAT_ALLOCATED;
                    r_wr_pend <= 1'b1;
                end
            end
            ST_FREE_CHK: begin
                r_wr_data <= w_cur_word & ~(WORD_W'(1) << r_idx[BIT_W-1:0]);
                if (w_free_ok) begin
                    r_status  <= STAT_FREED;
                    r_wr_pend <= 1'b1;
                end else begin
                    r_status  <= STAT_NOT_ALLOC;
                    r_wr_pend <= 1'b0;
                end
            end
            ST_DONE: begin
                r_first <= 1'b0;
            end
            default: begin
                r_first <= 1'b0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_status <= r_status;
            r_out_bytes  <= n_free_cnt;
            if (r_status == STAT_ALLOCATED) begin
                r_out_addr <= ADDR_W'({r_idx, {SLICE_LOG2{1'b0}}});
            end else begin
                r_out_addr <= '0;
            end
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.slice_address = r_out_addr;
    assign o_rsp.free_bytes    = r_out_bytes;

    `BSA_ASSERT_ALWAYS(a_cnt_aligned, r_free_cnt[SLICE_LOG2-1:0] == '0,
        "free byte count not a whole number of slices")
    `BSA_ASSERT_ALWAYS(a_cnt_bounded, r_free_cnt <= FREE_RESET,
        "free byte count above pool size less bitmap")
    `BSA_ASSERT_NEXT(a_alloc_debits, w_finish && r_status == STAT_ALLOCATED,
        r_free_cnt == $past(r_free_cnt) - CNT_W'(SLICE_BYTES),
        "allocation did not take one slice off the count")
    `BSA_ASSERT_IMPLY(a_alloc_not_tail, o_rsp.valid && o_rsp.status == STAT_ALLOCATED,
        int'(o_rsp.slice_address) < TAIL_FIRST * SLICE_BYTES,
        "allocated a slice that holds the bitmap")
    `BSA_ASSERT_IMPLY(a_scan_from_hint, r_state == ST_SCAN,
        r_chk_word >= r_hint[IDX_W-1:BIT_W],
        "scan word below the lowest-free hint")

endmodule

FILE: hw/rtl/bsa_ram.sv
module bsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: tb/tb_bitmap_slice_allocator.sv
module tb_bitmap_slice_allocator;
    import bsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1130;
    localparam int TAIL_ITEMS   = 120;
    localparam int SETTLE_CYCLES = 140;

    // Pool image: bitmap words, search hint, free byte count
    typedef struct packed {
        logic [NUM_WORDS-1:0][WORD_W-1:0] map;
        logic [IDX_W:0]                   hint;
        logic [CNT_W-1:0]                 avail;
    } pool_image_t;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] slice_address;
        logic [CNT_W-1:0]  free_bytes;
    } slice_result_t;

    // An entry of the send queue; a hold entry stops the sender until all results are back
    typedef struct packed {
        logic              hold;
        logic              kind;
        logic [ADDR_W-1:0] addr;
    } req_item_t;

    localparam req_item_t HOLD_ITEM = {1'b1, REQ_ALLOC, {ADDR_W{1'b0}}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              req_valid = 1'b0;
    logic              req_kind  = REQ_ALLOC;
    logic [ADDR_W-1:0] req_addr  = '0;
    logic              rsp_ready = 1'b0;
    logic              req_fire  = 1'b0;

    int send_gap   = 0;
    int stall_left = 0;
    int fault_count = 0;

    req_item_t     pending[$];
    slice_result_t expected[$];
    int            held[$];
    pool_image_t   plan_pool;
    pool_image_t   live_pool;

    bsa_req_if req_ch ();
    bsa_rsp_if rsp_ch ();

    assign req_ch.valid        = req_valid;
    assign req_ch.req_type     = req_kind;
    assign req_ch.free_address = req_addr;
    assign rsp_ch.ready        = rsp_ready;

    bitmap_slice_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Pool after reset: only the slices that hold the bitmap are taken
    function automatic pool_image_t fresh_pool();
        pool_image_t p;
        p.map = '0;
        for (int i = TAIL_FIRST; i < NUM_SLICES; i++) begin
            p.map[i / WORD_W][i % WORD_W] = 1'b1;
        end
        p.hint  = '0;
        p.avail = FREE_RESET;
        return p;
    endfunction

    // Apply one alloc or free to a pool image and return the result it gives
    function automatic slice_result_t serve_request(inout pool_image_t p, input logic kind,
                                                    input logic [ADDR_W-1:0] addr);
        slice_result_t r;
        int  slot;
        logic found;
        r.status        = STAT_FULL;
        r.slice_address = '0;
        found = 1'b0;
        slot  = 0;
        if (kind == REQ_ALLOC) begin
            if (p.avail != 0) begin
                for (int i = int'(p.hint); i < NUM_SLICES && !found; i++) begin
                    if (!p.map[i / WORD_W][i % WORD_W]) begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
                if (found) begin
                    p.map[slot / WORD_W][slot % WORD_W] = 1'b1;
                    p.avail = CNT_W'(int'(p.avail) - SLICE_BYTES);
                    p.hint  = (IDX_W + 1)'(slot + 1);
                    r.slice_address = ADDR_W'(slot << SLICE_LOG2);
                    r.status = STAT_ALLOCATED;
                end
            end
        end else begin
            slot = int'(addr >> SLICE_LOG2) % NUM_SLICES;
            if (slot < TAIL_FIRST && p.map[slot / WORD_W][slot % WORD_W]) begin
                p.map[slot / WORD_W][slot % WORD_W] = 1'b0;
                p.avail  = CNT_W'(int'(p.avail) + SLICE_BYTES);
                r.status = STAT_FREED;
            end else begin
                r.status = STAT_NOT_ALLOC;
            end
            if (int'(p.hint) > slot) begin
                p.hint = (IDX_W + 1)'(slot);
            end
        end
        r.free_bytes = p.avail;
        return r;
    endfunction

    // Queue a request and track which slices it leaves allocated
    task automatic queue_request(input logic kind, input logic [ADDR_W-1:0] addr);
        req_item_t     it;
        slice_result_t r;
        int            slot;
        int            hit;
        it.hold = 1'b0;
        it.kind = kind;
        it.addr = addr;
        pending.push_back(it);
        r = serve_request(plan_pool, kind, addr);
        if (r.status == STAT_ALLOCATED) begin
            held.push_back(int'(r.slice_address >> SLICE_LOG2));
        end else if (r.status == STAT_FREED) begin
            slot = int'(addr >> SLICE_LOG2);
            hit  = -1;
            foreach (held[k]) begin
                if (held[k] == slot) hit = k;
            end
            if (hit >= 0) held.delete(hit);
        end
    endtask

    // Drive requests at the falling edge, with random gaps between items
    always @(negedge i_clk) begin : drive_req
        req_item_t it;
        if (i_rst_n && (!req_valid || req_fire)) begin
            if (send_gap != 0) begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end else if (pending.size() != 0 && pending[0].hold) begin
                req_valid <= 1'b0;
                if (expected.size() == 0) begin
                    it = pending.pop_front();
                end
            end else if (pending.size() != 0) begin
                it = pending.pop_front();
                req_valid <= 1'b1;
                req_kind  <= it.kind;
                req_addr  <= it.addr;
                if (pending.size() >= TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(1, 14);
                end
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // Stall the result side in random bursts
    always @(negedge i_clk) begin : drive_ready
        if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            rsp_ready <= 1'b1;
            if (pending.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(1, 14);
            end
        end
    end

    // Predict on every accepted request, check every accepted result
    always @(posedge i_clk) begin : score
        slice_result_t want;
        req_fire <= req_valid && req_ch.ready;
        if (i_rst_n) begin
            if (req_valid && req_ch.ready) begin
                expected.push_back(serve_request(live_pool, req_kind, req_addr));
            end
            if (rsp_ch.valid && rsp_ready) begin
                if (expected.size() == 0) begin
                    $error("unexpected result item: status %0d, slice_address %0d",
                           rsp_ch.status, rsp_ch.slice_address);
                    fault_count++;
                end else begin
                    want = expected.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        fault_count++;
                    end
                    if (rsp_ch.slice_address !== want.slice_address) begin
                        $error("slice_address: expected %0d, got %0d",
                               want.slice_address, rsp_ch.slice_address);
                        fault_count++;
                    end
                    if (rsp_ch.free_bytes !== want.free_bytes) begin
                        $error("free_bytes: expected %0d, got %0d",
                               want.free_bytes, rsp_ch.free_bytes);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Build the request list, release reset, wait for the last result
    initial begin : stimulus
        int seg_left;
        int alloc_pct;
        int k;
        logic [ADDR_W-1:0] a;
        plan_pool = fresh_pool();
        live_pool = fresh_pool();
        seg_left  = 0;
        alloc_pct = 50;

        // Directed: lowest slices, unaligned and double free, tail slices, hint drop
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_FREE, ADDR_W'(SLICE_BYTES + 37));
        queue_request(REQ_FREE, ADDR_W'(SLICE_BYTES));
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_FREE, {ADDR_W{1'b1}});
        queue_request(REQ_FREE, ADDR_W'(TAIL_FIRST << SLICE_LOG2));
        queue_request(REQ_FREE, '0);
        queue_request(REQ_FREE, '0);
        queue_request(REQ_FREE, ADDR_W'((2000 << SLICE_LOG2) + 63));
        queue_request(REQ_ALLOC, '0);
        queue_request(REQ_ALLOC, {ADDR_W{1'b1}});
        queue_request(REQ_FREE, ADDR_W'(2 << SLICE_LOG2));
        queue_request(REQ_FREE, ADDR_W'((3 << SLICE_LOG2) + 63));
        queue_request(REQ_ALLOC, '0);

        // Poke the first tail slice, then let every result drain
        queue_request(REQ_FREE, ADDR_W'(TAIL_FIRST << SLICE_LOG2));
        pending.push_back(HOLD_ITEM);

        // Random mix in segments that lean toward filling or draining the pool
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 160);
                case ($urandom_range(0, 2))
                    0: alloc_pct = 15;
                    1: alloc_pct = 50;
                    default: alloc_pct = 85;
                endcase
                if ($urandom_range(0, 3) == 0) pending.push_back(HOLD_ITEM);
            end
            seg_left--;
            if ($urandom_range(0, 99) < alloc_pct) begin
                queue_request(REQ_ALLOC, ADDR_W'($urandom_range(0, POOL_BYTES - 1)));
            end else if (held.size() != 0 && $urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, held.size() - 1);
                a = ADDR_W'(held[k] << SLICE_LOG2) |
                    ADDR_W'($urandom_range(0, SLICE_BYTES - 1));
                queue_request(REQ_FREE, a);
            end else if ($urandom_range(0, 2) == 0) begin
                queue_request(REQ_FREE,
                    ADDR_W'($urandom_range(TAIL_FIRST << SLICE_LOG2, POOL_BYTES - 1)));
            end else begin
                queue_request(REQ_FREE, ADDR_W'($urandom_range(0, POOL_BYTES - 1)));
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || req_valid || expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected.size() != 0) begin
            $error("%0d result items never arrived", expected.size());
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
